// ===== design/rbps_pkg.sv =====
// Package with sizes, op codes and register indexes of the pressure solver.
`default_nettype none
package rbps_pkg;
  localparam int MAX_X = 16;
  localparam int MAX_Y = 16;
  localparam int MAX_Z = 16;
  localparam int XW = $clog2(MAX_X) > 0 ? $clog2(MAX_X) : 1;
  localparam int YW = $clog2(MAX_Y) > 0 ? $clog2(MAX_Y) : 1;
  localparam int ZW = $clog2(MAX_Z) > 0 ? $clog2(MAX_Z) : 1;
  localparam int CELLS = MAX_X * MAX_Y * MAX_Z;
  localparam int AW = $clog2(CELLS) > 0 ? $clog2(CELLS) : 1;

  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_RUN  = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  localparam logic [2:0] REG_SIZE_X = 3'd0;
  localparam logic [2:0] REG_SIZE_Y = 3'd1;
  localparam logic [2:0] REG_SIZE_Z = 3'd2;
  localparam logic [2:0] REG_SWEEPS = 3'd3;
  localparam logic [2:0] REG_H2     = 3'd4;

  typedef struct packed {
    logic [1:0]  op;
    logic [3:0]  cell_x;
    logic [3:0]  cell_y;
    logic [3:0]  cell_z;
    logic signed [31:0] divergence_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  done_op;
    logic signed [31:0] pressure_value;
  } out_item_t;
endpackage
`default_nettype wire

// ===== design/rbps_if.sv =====
// Valid/ready channel interface carrying one item.
`default_nettype none
interface rbps_in_if;
  logic valid;
  logic ready;
  rbps_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rbps_out_if;
  logic valid;
  logic ready;
  rbps_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== design/red_black_pressure_solve.sv =====
// Red-black Gauss-Seidel pressure Poisson solver top level.
// A load or no-op item goes through S_OUT to its registered result, a read through S_RD, S_RDW
// and S_OUT; the next item is taken the cycle after the result leaves (one memory port, one divider).
// A run first clears all 4096 pressure entries; each iteration then makes a pass per parity,
// giving each cell of that parity neighbor reads, setup, a divide, write and step, and only
// stepping past the others. Reset is synchronous, active low; it clears control state and
// registers and then runs the same clear of the pressure store, with the input not ready meanwhile.
`default_nettype none
module red_black_pressure_solve (
  input  wire logic        clk,
  input  wire logic        rst_n,
  rbps_in_if.sink          in_ch,
  rbps_out_if.source       out_ch,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  import rbps_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0, S_RD = 4'd1, S_RDW = 4'd2, S_OUT = 4'd3,
                         S_CELL = 4'd4, S_NB = 4'd5, S_MUL = 4'd6, S_DIV = 4'd7,
                         S_WR = 4'd8, S_NEXT = 4'd9, S_CLR = 4'd10;

  logic [4:0]  size_x_r, size_y_r, size_z_r;
  logic [7:0]  sweeps_r;
  logic [31:0] h2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_x_r <= 5'd16; size_y_r <= 5'd16; size_z_r <= 5'd16;
      sweeps_r <= 8'd20; h2_r <= 32'd65536;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SIZE_X: size_x_r <= cfg_data[4:0];
        REG_SIZE_Y: size_y_r <= cfg_data[4:0];
        REG_SIZE_Z: size_z_r <= cfg_data[4:0];
        REG_SWEEPS: sweeps_r <= cfg_data[7:0];
        REG_H2:     h2_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamped sizes minus one, as axis maxima.
  logic [XW-1:0] lx;
  logic [YW-1:0] ly;
  logic [ZW-1:0] lz;
  always_comb begin
    lx = (size_x_r == 5'd0) ? '0 : (32'(size_x_r) > MAX_X) ? XW'(MAX_X - 1)
         : XW'(size_x_r - 5'd1);
    ly = (size_y_r == 5'd0) ? '0 : (32'(size_y_r) > MAX_Y) ? YW'(MAX_Y - 1)
         : YW'(size_y_r - 5'd1);
    lz = (size_z_r == 5'd0) ? '0 : (32'(size_z_r) > MAX_Z) ? ZW'(MAX_Z - 1)
         : ZW'(size_z_r - 5'd1);
  end

  logic [31:0] div_mem [CELLS];
  logic [31:0] p_mem [CELLS];

  logic [3:0]  state_r;
  in_item_t    item_r;
  out_item_t   res_r;
  logic        res_valid_r;
  logic [XW-1:0] x_r;
  logic [YW-1:0] y_r;
  logic [ZW-1:0] z_r;
  logic        parity_r;
  logic [7:0]  iter_r;
  logic [2:0]  nb_r;
  logic signed [35:0] sum_r;
  logic [2:0]  cnt_r;
  logic signed [63:0] prod_r;
  logic [6:0]  dstep_r;
  logic [63:0] rem_r;
  logic [63:0] quo_r;
  logic        neg_r;
  logic [AW-1:0] clr_r;
  logic        acc_v_r;

  // Memory port: one read address a cycle, read data registered.
  logic [AW-1:0] raddr;
  logic [31:0]   prd_r, drd_r;
  logic          p_we;
  logic [AW-1:0] waddr;
  logic [31:0]   wdata;
  logic          d_we;

  function automatic logic [AW-1:0] addr_of(input logic [XW-1:0] x,
      input logic [YW-1:0] y, input logic [ZW-1:0] z);
    addr_of = AW'((32'(z) * MAX_Y + 32'(y)) * MAX_X + 32'(x));
  endfunction

  // Neighbor selection for step nb_r: -x,+x,-y,+y,-z,+z.
  logic nb_in;
  logic [XW-1:0] nx_c;
  logic [YW-1:0] ny_c;
  logic [ZW-1:0] nz_c;
  always_comb begin
    nx_c = x_r; ny_c = y_r; nz_c = z_r; nb_in = 1'b0;
    unique case (nb_r)
      3'd0: begin nb_in = x_r != '0; nx_c = x_r - 1'b1; end
      3'd1: begin nb_in = x_r != lx; nx_c = x_r + 1'b1; end
      3'd2: begin nb_in = y_r != '0; ny_c = y_r - 1'b1; end
      3'd3: begin nb_in = y_r != ly; ny_c = y_r + 1'b1; end
      3'd4: begin nb_in = z_r != '0; nz_c = z_r - 1'b1; end
      3'd5: begin nb_in = z_r != lz; nz_c = z_r + 1'b1; end
      default: ;
    endcase
  end

  logic in_range;
  assign in_range = (32'(item_r.cell_x) < MAX_X) && (32'(item_r.cell_y) < MAX_Y)
                 && (32'(item_r.cell_z) < MAX_Z);

  logic par_ok;
  assign par_ok = (x_r[0] ^ y_r[0] ^ z_r[0]) == parity_r;

  always_comb begin
    if (state_r == S_RD || state_r == S_RDW)
      raddr = addr_of(XW'(item_r.cell_x), YW'(item_r.cell_y), ZW'(item_r.cell_z));
    else if (state_r == S_NB)
      raddr = addr_of(nx_c, ny_c, nz_c);
    else
      raddr = addr_of(x_r, y_r, z_r);
  end

  always_ff @(posedge clk) begin
    prd_r <= p_mem[raddr];
    drd_r <= div_mem[raddr];
    if (p_we) p_mem[waddr] <= wdata;
    if (d_we) div_mem[waddr] <= wdata;
  end

  logic [31:0] p_rd;
  assign p_rd = prd_r;

  // Truncated quotient and saturation.
  logic signed [64:0] q_s;
  logic [31:0] sat_q;
  always_comb begin
    q_s = neg_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});
    if (q_s > 65'sd2147483647) sat_q = 32'h7fffffff;
    else if (q_s < -65'sd2147483648) sat_q = 32'h80000000;
    else sat_q = q_s[31:0];
  end

  // Divergence term and numerator.
  logic signed [63:0] term_c;
  logic signed [63:0] num_c;
  assign term_c = (prod_r < 0) ? -((-prod_r) >>> 16) : (prod_r >>> 16);
  assign num_c = 64'(sum_r) - term_c;

  logic last_cell;
  assign last_cell = (x_r == lx) && (y_r == ly) && (z_r == lz);

  logic [63:0] trial;
  assign trial = {rem_r[62:0], quo_r[63]};

  assign p_we = (state_r == S_CLR) || (state_r == S_WR) ||
                (state_r == S_CELL && par_ok && nb_r == 3'd6 && cnt_r == 3'd0);
  assign waddr = (state_r == S_IDLE)
               ? addr_of(XW'(in_ch.data.cell_x), YW'(in_ch.data.cell_y),
                         ZW'(in_ch.data.cell_z))
               : (state_r == S_CLR) ? clr_r : addr_of(x_r, y_r, z_r);
  assign wdata = (state_r == S_IDLE) ? in_ch.data.divergence_value
               : (state_r == S_WR) ? sat_q : 32'd0;
  assign d_we = (state_r == S_IDLE) && in_ch.valid && in_ch.ready &&
                in_ch.data.op == OP_LOAD &&
                (32'(in_ch.data.cell_x) < MAX_X) && (32'(in_ch.data.cell_y) < MAX_Y)
                && (32'(in_ch.data.cell_z) < MAX_Z);

  assign in_ch.ready = (state_r == S_IDLE) && !res_valid_r;
  assign out_ch.valid = res_valid_r;
  assign out_ch.data = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR; res_valid_r <= 1'b0; clr_r <= '0; item_r <= '0;
      parity_r <= 1'b0; iter_r <= 8'd0; nb_r <= 3'd0; dstep_r <= 7'd0;
    end else begin
      if (out_ch.valid && out_ch.ready) res_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: if (in_ch.valid && in_ch.ready) begin
          item_r <= in_ch.data;
          if (in_ch.data.op == OP_RUN) begin
            clr_r <= '0;
            iter_r <= 8'd0; parity_r <= 1'b0;
            x_r <= '0; y_r <= '0; z_r <= '0; nb_r <= 3'd7;
            state_r <= S_CLR;
          end else if (in_ch.data.op == OP_READ) state_r <= S_RD;
          else state_r <= S_OUT;
        end
        S_CLR: begin
          // One pressure entry is zeroed per cycle, after reset and at the start of a run.
          clr_r <= clr_r + 1'b1;
          if (clr_r == AW'(CELLS - 1)) begin
            if (item_r.op == OP_RUN) state_r <= (sweeps_r == 8'd0) ? S_OUT : S_CELL;
            else state_r <= S_IDLE;
          end
        end
        S_RD: state_r <= S_RDW;
        S_RDW: state_r <= S_OUT;
        S_OUT: begin
          res_r.done_op <= item_r.op;
          res_r.pressure_value <= (item_r.op == OP_READ && in_range) ? p_rd : 32'd0;
          res_valid_r <= 1'b1;
          if (item_r.op == OP_RUN) begin
            iter_r <= sweeps_r; parity_r <= 1'b0;
          end
          state_r <= S_IDLE;
        end
        S_CELL: begin
          // nb_r==7 marks the first visit of a cell, nb_r==6 the return after the neighbors.
          if (!par_ok) begin
            state_r <= S_NEXT;
          end else if (nb_r == 3'd7) begin
            sum_r <= '0; cnt_r <= 3'd0; nb_r <= 3'd0; state_r <= S_NB;
          end else if (cnt_r == 3'd0) begin
            nb_r <= 3'd7; state_r <= S_NEXT;
          end else begin
            // All neighbors folded in; divergence read is in drd_r.
            prod_r <= $signed(drd_r) * $signed({1'b0, h2_r});
            state_r <= S_MUL;
          end
        end
        S_NB: begin
          // Issue neighbor read nb_r; fold the one issued in the previous cycle.
          if (acc_v_r) begin
            sum_r <= sum_r + 36'($signed(p_rd));
            cnt_r <= cnt_r + 3'd1;
          end
          if (nb_r == 3'd6) state_r <= S_CELL;
          else nb_r <= nb_r + 3'd1;
        end
        S_MUL: begin
          neg_r <= num_c < 0;
          quo_r <= (num_c < 0) ? 64'(-num_c) : 64'(num_c);
          rem_r <= '0; dstep_r <= 7'd0; state_r <= S_DIV;
        end
        S_DIV: begin
          if (trial >= 64'(cnt_r)) begin
            rem_r <= trial - 64'(cnt_r);
            quo_r <= {quo_r[62:0], 1'b1};
          end else begin
            rem_r <= trial;
            quo_r <= {quo_r[62:0], 1'b0};
          end
          dstep_r <= dstep_r + 7'd1;
          if (dstep_r == 7'd63) state_r <= S_WR;
        end
        S_WR: begin
          nb_r <= 3'd7; state_r <= S_NEXT;
        end
        S_NEXT: begin
          nb_r <= 3'd7; state_r <= S_CELL;
          if (last_cell) begin
            x_r <= '0; y_r <= '0; z_r <= '0;
            if (parity_r) begin
              parity_r <= 1'b0;
              if (iter_r + 8'd1 == sweeps_r) state_r <= S_OUT;
              iter_r <= iter_r + 8'd1;
            end else parity_r <= 1'b1;
          end else if (x_r != lx) x_r <= x_r + 1'b1;
          else begin
            x_r <= '0;
            if (y_r != ly) y_r <= y_r + 1'b1;
            else begin y_r <= '0; z_r <= z_r + 1'b1; end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // A neighbor read issued in S_NB has its data in prd_r in the next cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) acc_v_r <= 1'b0;
    else acc_v_r <= (state_r == S_NB) && nb_in;
  end

`ifndef SYNTHESIS
  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> !in_ch.ready) else $error("ready while busy");
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_OUT |=> res_valid_r) else $error("result missing");
  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> cnt_r != 3'd0) else $error("divide by zero count");
`endif
endmodule
`default_nettype wire
